### rtl/swrr_pkg.sv
// Shared types and constants of the sliding window reorder receiver.
// Depends on nothing; every module of the block imports it.
package swrr_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int LEN_BITS   = 11;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int WIN_W      = 6;
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(MAX_WINDOW);
    localparam logic [31:0] HALF_SPACE = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_END   = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_ACK   = 2'd3
    } pkt_kind_t;

    typedef enum logic [1:0] {
        RES_STORE   = 2'd0,
        RES_DELIVER = 2'd1,
        RES_ACK     = 2'd2
    } res_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD,
        ST_CHK
    } rx_state_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [31:0]         seq_num;
        logic [31:0]         hdr_checksum;
        logic [31:0]         payload_crc;
        logic [LEN_BITS-1:0] length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          result_kind;
        logic [31:0]         seq_out;
        logic [SLOT_W-1:0]   slot;
        logic [LEN_BITS-1:0] length_out;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [31:0]         seq;
        logic [LEN_BITS-1:0] len;
    } slot_entry_t;

endpackage

### rtl/sliding_window_reorder_receiver.sv
// Top level of the sliding window reorder receiver: request sequencer, reorder
// store memory and output register. Depends on swrr_pkg.
//
// Usage
//   Input channel (s_valid/s_ready/s_data) carries one packet summary per
//   request. Output channel (m_valid/m_ready/m_data) carries result records:
//   store, deliver or ack, with last set on the final record of a request.
//   cfg_we/cfg_wdata write the receive window width; write only while idle.
//   A request is taken in ST_IDLE and decoded in ST_EXEC once the output
//   register has room; every record goes out through the output register.
//   A START that matches or finds none latched, an END and old data give
//   one ack; other requests give no record. Accepted data gives the store
//   record, then one deliver record per in-order packet, then the ack. Each
//   drain step reads the reorder store in ST_RD and checks it in ST_CHK.
//   Reset clears the connection state, expected sequence and all slot valid
//   bits at once; the store contents stay undefined until written.
//   When the receiver holds m_ready low, the output register holds its record
//   and the sequencer waits; s_ready stays low until the sequencer is done
//   with the request in hand, so no further request is taken meanwhile.
module sliding_window_reorder_receiver (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  swrr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output swrr_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [5:0]          cfg_wdata
);
    import swrr_pkg::*;

    // Control state
    rx_state_t             state_reg, state_next;
    logic                  connected_reg, connected_next;
    logic                  start_valid_reg, start_valid_next;
    logic [31:0]           start_seq_reg, start_seq_next;
    logic [31:0]           expected_reg, expected_next;
    logic [MAX_WINDOW-1:0] slot_valid_reg, slot_valid_next;
    logic [WIN_W-1:0]      window_reg;

    // Request and output registers
    in_item_t  req_reg;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    // Reorder store
    slot_entry_t       slot_mem [MAX_WINDOW];
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    slot_entry_t       mem_wdata;
    logic              mem_re;
    slot_entry_t       rd_data_reg;

    logic              out_free;
    logic [31:0]       ahead, behind;
    logic [WIN_W-1:0]  eff_win;
    logic              in_window, is_old;
    logic [SLOT_W-1:0] req_slot, exp_slot;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Window classification of the held request
    assign ahead   = req_reg.seq_num - expected_reg;
    assign behind  = expected_reg - req_reg.seq_num;
    assign eff_win = (window_reg == '0) ? WIN_W'(1) :
                     (window_reg > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : window_reg;
    assign in_window = ahead < {{(32-WIN_W){1'b0}}, eff_win};
    assign is_old    = (behind != 32'd0) && (behind <= HALF_SPACE);
    assign req_slot  = req_reg.seq_num[SLOT_W-1:0];
    assign exp_slot  = expected_reg[SLOT_W-1:0];

    // Hold the request while the sequencer works on it
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WIN_RESET;
        end else if (cfg_we) begin
            window_reg <= cfg_wdata;
        end
    end

    // Reorder store: one write port, one registered read port. The write of a
    // store lands in ST_EXEC, before the drain reads in ST_RD, so no forwarding.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= slot_mem[exp_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            connected_reg   <= 1'b0;
            start_valid_reg <= 1'b0;
            start_seq_reg   <= '0;
            expected_reg    <= '0;
            slot_valid_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            connected_reg   <= connected_next;
            start_valid_reg <= start_valid_next;
            start_seq_reg   <= start_seq_next;
            expected_reg    <= expected_next;
            slot_valid_reg  <= slot_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next       = state_reg;
        connected_next   = connected_reg;
        start_valid_next = start_valid_reg;
        start_seq_next   = start_seq_reg;
        expected_next    = expected_reg;
        slot_valid_next  = slot_valid_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        mem_we           = 1'b0;
        mem_waddr        = req_slot;
        mem_wdata.seq    = req_reg.seq_num;
        mem_wdata.len    = req_reg.length;
        mem_re           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Wait for room in the output register before acting
                if (out_free) begin
                    state_next = ST_IDLE;
                    unique case (pkt_kind_t'(req_reg.kind))
                        KIND_START: begin
                            // Drop a START that does not match the latched one
                            if (!start_valid_reg || start_seq_reg == req_reg.seq_num) begin
                                start_seq_next   = req_reg.seq_num;
                                start_valid_next = 1'b1;
                                connected_next   = 1'b1;
                                expected_next    = '0;
                                slot_valid_next  = '0;
                                m_valid_next     = 1'b1;
                                m_data_next      = '{RES_ACK, req_reg.seq_num, '0, '0, 1'b1};
                            end
                        end
                        KIND_END: begin
                            connected_next   = 1'b0;
                            start_valid_next = 1'b0;
                            m_valid_next     = 1'b1;
                            m_data_next      = '{RES_ACK, req_reg.seq_num, '0, '0, 1'b1};
                        end
                        KIND_DATA: begin
                            if (connected_reg && req_reg.hdr_checksum == req_reg.payload_crc) begin
                                if (in_window) begin
                                    mem_we                    = 1'b1;
                                    slot_valid_next[req_slot] = 1'b1;
                                    m_valid_next              = 1'b1;
                                    m_data_next = '{RES_STORE, req_reg.seq_num, req_slot,
                                                    req_reg.length, 1'b0};
                                    state_next  = ST_RD;
                                end else if (is_old) begin
                                    m_valid_next = 1'b1;
                                    m_data_next  = '{RES_ACK, req_reg.seq_num, '0, '0, 1'b1};
                                end
                            end
                        end
                        KIND_ACK: begin
                        end
                    endcase
                end
            end
            ST_RD: begin
                // Fetch the slot of the expected sequence
                mem_re     = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (slot_valid_reg[exp_slot] && rd_data_reg.seq == expected_reg) begin
                        // Deliver, free the slot and advance
                        m_data_next = '{RES_DELIVER, expected_reg, exp_slot,
                                        rd_data_reg.len, 1'b0};
                        slot_valid_next[exp_slot] = 1'b0;
                        expected_next = expected_reg + 32'd1;
                        state_next    = ST_RD;
                    end else begin
                        m_data_next = '{RES_ACK, req_reg.seq_num, '0, '0, 1'b1};
                        state_next  = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // Assertions
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("request accepted without moving to decode");

    a_chk_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHK) |-> ($past(state_reg) == ST_RD || $past(state_reg) == ST_CHK))
        else $error("slot check without a preceding store read");

    a_deliver_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == RES_DELIVER) |->
        (m_data.slot == m_data.seq_out[SLOT_W-1:0] && !m_data.last))
        else $error("delivery record with inconsistent slot or last");

    a_store_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == RES_STORE) |-> !m_data.last)
        else $error("store record marked last");

    a_no_store_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD || state_reg == ST_CHK) |-> !mem_we)
        else $error("store written during drain");

endmodule

### sim/tb_top.sv
// Self-checking testbench of the sliding window reorder receiver: directed packet cases,
// window settings, full-window drain, back-pressure and random packet traffic.
// Depends on swrr_pkg and the sliding_window_reorder_receiver RTL.
module tb_top;
    import swrr_pkg::*;

    localparam int STALL_LIMIT  = 3000;  // cycles with no transfer before giving up
    localparam int QUIET_CYCLES = 16;    // settle time before a window write
    localparam int DRAIN_CYCLES = 100;   // settle time after the last owed record
    localparam int HOLD_CYCLES  = 400;
    localparam int LEN_MAX      = (1 << LEN_BITS) - 1;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_item_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_item_t        m_data;
    logic             cfg_we    = 1'b0;
    logic [WIN_W-1:0] cfg_wdata = '0;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_request  = 0;
    int errors        = 0;
    int stall_cycles  = 0;
    bit offering      = 1'b0;  // s_valid is (or is about to be) high

    // Receiver state as the predictor sees it
    logic [WIN_W-1:0]    rx_window     = WIN_RESET;
    logic                rx_connected  = 1'b0;
    logic                rx_start_held = 1'b0;
    logic [31:0]         rx_start_seq  = '0;
    logic [31:0]         rx_next_seq   = '0;
    logic                rx_slot_used [MAX_WINDOW] = '{default: 1'b0};
    logic [31:0]         rx_slot_seq  [MAX_WINDOW];
    logic [LEN_BITS-1:0] rx_slot_len  [MAX_WINDOW];

    // Records still owed by the block, oldest first
    out_item_t expected_records[$];

    always #5 aclk = ~aclk;

    sliding_window_reorder_receiver u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------- predictor

    // Window width in force: zero behaves as one, anything wider clamps to the store size
    function automatic logic [31:0] win_eff();
        if (rx_window == '0) return 32'd1;
        if (int'(rx_window) > MAX_WINDOW) return 32'(MAX_WINDOW);
        return 32'(rx_window);
    endfunction

    function automatic out_item_t make_rec(input res_kind_t k, input logic [31:0] seq,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [LEN_BITS-1:0] len);
        out_item_t r;
        r.result_kind = k;
        r.seq_out     = seq;
        r.slot        = slot;
        r.length_out  = len;
        r.last        = 1'b0;
        return r;
    endfunction

    // Work out the records one accepted request causes, queue them, return how many
    function automatic int predict_packet(input in_item_t p);
        out_item_t           recs[$];
        logic [31:0]         ahead;
        logic [31:0]         behind;
        logic [SLOT_W-1:0]   idx;
        int                  drained;
        ahead   = p.seq_num - rx_next_seq;
        behind  = rx_next_seq - p.seq_num;
        drained = 0;
        if (p.kind == KIND_START) begin
            // a latched start only answers to its own number
            if (!rx_start_held || rx_start_seq == p.seq_num) begin
                rx_start_seq  = p.seq_num;
                rx_start_held = 1'b1;
                rx_connected  = 1'b1;
                rx_next_seq   = '0;
                foreach (rx_slot_used[i]) rx_slot_used[i] = 1'b0;
                recs = {recs, make_rec(RES_ACK, p.seq_num, '0, '0)};
            end
        end else if (p.kind == KIND_END) begin
            recs = {recs, make_rec(RES_ACK, p.seq_num, '0, '0)};
            rx_connected  = 1'b0;
            rx_start_held = 1'b0;
        end else if (p.kind == KIND_DATA && rx_connected && p.hdr_checksum == p.payload_crc) begin
            if (ahead < win_eff()) begin
                idx = SLOT_W'(p.seq_num % 32'(MAX_WINDOW));
                rx_slot_used[idx] = 1'b1;
                rx_slot_seq[idx]  = p.seq_num;
                rx_slot_len[idx]  = p.length;
                recs = {recs, make_rec(RES_STORE, p.seq_num, idx, p.length)};
                // release the in-order run now sitting in the store
                while (drained < MAX_WINDOW) begin
                    idx = SLOT_W'(rx_next_seq % 32'(MAX_WINDOW));
                    if (!rx_slot_used[idx] || rx_slot_seq[idx] != rx_next_seq) break;
                    recs = {recs, make_rec(RES_DELIVER, rx_next_seq, idx, rx_slot_len[idx])};
                    rx_slot_used[idx] = 1'b0;
                    rx_next_seq++;
                    drained++;
                end
                recs = {recs, make_rec(RES_ACK, p.seq_num, '0, '0)};
            end else if (behind != '0 && behind <= HALF_SPACE) begin
                // already delivered: acknowledge again, store nothing
                recs = {recs, make_rec(RES_ACK, p.seq_num, '0, '0)};
            end
        end
        if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
        expected_records = {expected_records, recs};
        return recs.size();
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [LEN_BITS-1:0] rand_len();
        return LEN_BITS'($urandom_range(LEN_MAX));
    endfunction

    function automatic in_item_t make_packet(input pkt_kind_t k, input logic [31:0] seq,
                                             input logic [31:0] chk, input logic [31:0] crc,
                                             input logic [LEN_BITS-1:0] len);
        in_item_t p;
        p.kind         = k;
        p.seq_num      = seq;
        p.hdr_checksum = chk;
        p.payload_crc  = crc;
        p.length       = len;
        return p;
    endfunction

    // Data packet with a matching checksum of random value
    function automatic in_item_t make_data(input logic [31:0] seq,
                                           input logic [LEN_BITS-1:0] len);
        logic [31:0] crc;
        crc = $urandom;
        return make_packet(KIND_DATA, seq, crc, crc, len);
    endfunction

    function automatic void shuffle_offsets(input int m, output int order[$]);
        int r;
        int tmp;
        order.delete();
        for (int i = 0; i < m; i++) order = {order, i};
        for (int i = m - 1; i > 0; i--) begin
            r        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[r];
            order[r] = tmp;
        end
    endfunction

    // Offer one request, after a random gap, and predict it once taken
    task automatic send_packet(input in_item_t p, output int produced);
        int gap;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0 && offering) begin
            s_valid  <= 1'b0;
            offering  = 1'b0;
        end
        // never lower and raise valid within one step
        if (!offering) repeat (gap > 0 ? gap : 1) @(posedge aclk);
        s_valid  <= 1'b1;
        s_data   <= p;
        offering  = 1'b1;
        do @(posedge aclk); while (!s_ready);
        produced = predict_packet(p);
    endtask

    // Drop valid and wait until every owed record has come, then a little longer
    task automatic wait_drained(input int quiet);
        if (offering) begin
            s_valid  <= 1'b0;
            offering  = 1'b0;
        end
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (quiet) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] w);
        wait_drained(QUIET_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        rx_window  = w;
    endtask

    // ---------------------------------------------------------------- tests

    // Every packet type and each special case once, field extremes included
    task automatic test_directed_cases();
        int n;
        // ack packets and data on a closed connection are ignored
        send_packet(make_packet(KIND_ACK, '1, '1, '1, LEN_BITS'(LEN_MAX)), n);
        send_packet(make_packet(KIND_DATA, '0, '0, '0, '0), n);
        // end is acknowledged even while closed
        send_packet(make_packet(KIND_END, 32'h0000_1234, $urandom, $urandom, '0), n);
        send_packet(make_packet(KIND_START, '1, '0, '1, '0), n);
        // start with another number while one is latched: drop
        send_packet(make_packet(KIND_START, 32'd5, $urandom, $urandom, rand_len()), n);
        send_packet(make_packet(KIND_DATA, 32'd2, '1, '1, LEN_BITS'(LEN_MAX)), n);
        // same start again: re-open and clear the store
        send_packet(make_packet(KIND_START, '1, $urandom, $urandom, rand_len()), n);
        send_packet(make_data(32'd1, 11'd7), n);
        send_packet(make_packet(KIND_DATA, '0, '0, '0, '0), n);
        // checksum mismatch: drop
        send_packet(make_packet(KIND_DATA, 32'd3, 32'd1, 32'd0, 11'd5), n);
        send_packet(make_data(32'd3, 11'd100), n);
        // duplicate inside the window overwrites its slot
        send_packet(make_data(32'd3, 11'd200), n);
        // old data, acknowledged only
        send_packet(make_data(32'd1, 11'd9), n);
        // one past the window edge, then the last slot in it
        send_packet(make_data(32'd34, rand_len()), n);
        send_packet(make_data(32'd33, rand_len()), n);
        // behind across the wrap, exactly half the space behind, just over half
        send_packet(make_data(32'hFFFF_FFFF, rand_len()), n);
        send_packet(make_data(32'h8000_0002, rand_len()), n);
        send_packet(make_data(32'h8000_0001, rand_len()), n);
        send_packet(make_data(32'd2, rand_len()), n);
        send_packet(make_packet(KIND_END, '0, '0, '0, '0), n);
        send_packet(make_data(32'd4, rand_len()), n);
        wait_drained(QUIET_CYCLES);
    endtask

    // Narrowest and clamped window widths
    task automatic test_window_settings();
        int n;
        write_window(6'd1);
        send_packet(make_packet(KIND_START, '0, $urandom, $urandom, rand_len()), n);
        send_packet(make_data(32'd1, rand_len()), n);
        send_packet(make_data(32'd0, rand_len()), n);
        // zero acts as one
        write_window(6'd0);
        send_packet(make_data(32'd2, rand_len()), n);
        send_packet(make_data(32'd1, rand_len()), n);
        // widest field value clamps to the store size
        write_window(6'h3F);
        send_packet(make_data(rx_next_seq + 32'(MAX_WINDOW), rand_len()), n);
        send_packet(make_data(rx_next_seq + 32'(MAX_WINDOW - 1), rand_len()), n);
        write_window(WIN_W'(MAX_WINDOW + 1));
        send_packet(make_data(rx_next_seq + 32'(MAX_WINDOW), rand_len()), n);
        send_packet(make_packet(KIND_END, $urandom, $urandom, $urandom, rand_len()), n);
        write_window(WIN_RESET);
    endtask

    // Fill every slot but the expected one, then release the lot in one request
    task automatic test_full_window_drain();
        int n;
        int order[$];
        send_packet(make_packet(KIND_START, $urandom, $urandom, $urandom, rand_len()), n);
        shuffle_offsets(MAX_WINDOW - 1, order);
        foreach (order[i]) send_packet(make_data(32'(order[i] + 1), rand_len()), n);
        send_packet(make_data(32'd0, rand_len()), n);
        send_packet(make_packet(KIND_END, $urandom, $urandom, $urandom, rand_len()), n);
        wait_drained(QUIET_CYCLES);
    endtask

    // Hold the result side off so the block fills and stalls its input
    task automatic test_backpressure();
        int n;
        int order[$];
        send_packet(make_packet(KIND_START, $urandom, $urandom, $urandom, rand_len()), n);
        hold_request = HOLD_CYCLES;
        shuffle_offsets(24, order);
        foreach (order[i]) send_packet(make_data(rx_next_seq + 32'(order[i]), rand_len()), n);
        send_packet(make_packet(KIND_END, $urandom, $urandom, $urandom, rand_len()), n);
        // pause the sender until every record is out
        wait_drained(0);
    endtask

    // Sessions of reordered data with noise mixed in
    task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
        int          productive;
        int          n;
        int          m;
        int          pick;
        int          order[$];
        logic [31:0] base;
        logic [31:0] start_num;
        in_item_t    pkt;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        productive    = 0;
        while (productive < n_items) begin
            start_num = $urandom;
            send_packet(make_packet(KIND_START, start_num, $urandom, $urandom, rand_len()), n);
            productive += (n > 0);
            // now and then a second start, matching or not
            if ($urandom_range(3) == 0) begin
                send_packet(make_packet(KIND_START, $urandom_range(1) ? start_num : $urandom,
                                        $urandom, $urandom, rand_len()), n);
                productive += (n > 0);
            end
            repeat ($urandom_range(1, 3)) begin
                m    = $urandom_range(1, win_eff() < 10 ? win_eff() : 10);
                base = rx_next_seq;
                shuffle_offsets(m, order);
                for (int j = 0; j < m; j++) begin
                    pick = $urandom_range(99);
                    if (pick < 20) begin
                        if (pick < 4)
                            pkt = make_packet(KIND_ACK, $urandom, $urandom, $urandom, rand_len());
                        else if (pick < 8)
                            pkt = make_packet(KIND_DATA, base + 32'(order[$urandom_range(m - 1)]),
                                              $urandom, $urandom, rand_len());
                        else if (pick < 12)
                            pkt = make_data(rx_next_seq - $urandom_range(1, 40), rand_len());
                        else if (pick < 16)
                            pkt = make_data(rx_next_seq + win_eff() + $urandom_range(40),
                                            rand_len());
                        else
                            pkt = make_data($urandom, rand_len());
                        send_packet(pkt, n);
                        productive += (n > 0);
                    end
                    send_packet(make_data(base + 32'(order[j]), rand_len()), n);
                    productive += (n > 0);
                end
            end
            // usually close the session; data after the close is dropped
            if ($urandom_range(4) != 0) begin
                send_packet(make_packet(KIND_END, $urandom, $urandom, $urandom, rand_len()), n);
                productive += (n > 0);
                if ($urandom_range(3) == 0)
                    send_packet(make_data(rx_next_seq, rand_len()), n);
            end
        end
    endtask

    // ---------------------------------------------------------------- result side

    // Drive ready at random, or hold it low for a requested stretch
    initial begin : sink_driver
        int held;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                held         = hold_request;
                hold_request = 0;
                m_ready     <= 1'b0;
                repeat (held) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // Compare each record taken against the oldest one owed
    always @(posedge aclk) begin : record_checker
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                $error("unexpected record: kind %0d seq %0h", m_data.result_kind, m_data.seq_out);
                errors++;
            end else begin
                want = expected_records.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(m_data.result_kind));
                check_field("seq_out", want.seq_out, m_data.seq_out);
                check_field("slot", 32'(want.slot), 32'(m_data.slot));
                check_field("length_out", 32'(want.length_out), 32'(m_data.length_out));
                check_field("last", 32'(want.last), 32'(m_data.last));
            end
        end
    end

    // Give up when nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL sliding_window_reorder_receiver");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : main_sequence
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct  = 36;
        sink_idle_pct = 54;
        test_directed_cases();
        test_window_settings();
        test_full_window_drain();
        test_backpressure();
        test_random_traffic(15, 36, 54);
        write_window(WIN_W'($urandom_range(0, (1 << WIN_W) - 1)));
        test_random_traffic(15, 54, 36);
        write_window(WIN_W'($urandom_range(1, MAX_WINDOW)));
        test_random_traffic(15, 0, 0);
        wait_drained(DRAIN_CYCLES);
        if (errors == 0) begin
            $display("PASS sliding_window_reorder_receiver");
        end else begin
            $display("FAIL sliding_window_reorder_receiver");
        end
        $finish;
    end

endmodule
